// ----- sv/ags_pkg.sv -----
// ----------------------------------------------------------------------------
// Array growth sizer package
// Shared widths, request/response structs and the growth chunk ladder.
// ----------------------------------------------------------------------------
package ags_pkg;

    // element count width (18..64)
    localparam int COUNT_WIDTH = 32;
    localparam int CHUNK_WIDTH = 16;
    localparam int SIZE_WIDTH  = 33;
    // width used for the final size sum before truncation
    localparam int SUM_WIDTH   = ((COUNT_WIDTH > SIZE_WIDTH) ? COUNT_WIDTH : SIZE_WIDTH) + 1;

    localparam int STEP_COUNT  = 20;
    localparam int LIMIT_WIDTH = 18;

    localparam logic [CHUNK_WIDTH-1:0] TOP_CHUNK = 16'd60750;

    typedef logic [LIMIT_WIDTH-1:0] t_limit_tab [STEP_COUNT];
    typedef logic [CHUNK_WIDTH-1:0] t_chunk_tab [STEP_COUNT];

    localparam t_limit_tab STEP_LIMIT = '{
        18'd2,     18'd4,     18'd8,     18'd16,    18'd64,    18'd192,
        18'd288,   18'd432,   18'd648,   18'd972,   18'd1458,  18'd2916,
        18'd4374,  18'd8748,  18'd13122, 18'd26244, 18'd39366, 18'd65610,
        18'd109350, 18'd182250
    };

    localparam t_chunk_tab STEP_CHUNK = '{
        16'd1,     16'd2,     16'd4,     16'd8,     16'd16,    16'd32,
        16'd48,    16'd72,    16'd108,   16'd162,   16'd243,   16'd486,
        16'd729,   16'd1458,  16'd2187,  16'd4374,  16'd6561,  16'd13122,
        16'd21870, 16'd36450
    };

    // sizing request
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] element_count;
        logic [CHUNK_WIDTH-1:0] current_chunk;
    } t_req;

    // sizing response
    typedef struct packed {
        logic [CHUNK_WIDTH-1:0] chunk_size;
        logic [SIZE_WIDTH-1:0]  array_size;
    } t_rsp;

    // data handed from cell to cell along the remainder chain
    typedef struct packed {
        logic                   valid;
        logic [COUNT_WIDTH-1:0] count;   // rotated one bit per cell
        logic [CHUNK_WIDTH-1:0] chunk;   // divisor, never zero
        logic [CHUNK_WIDTH-1:0] rem;     // partial remainder
    } t_lane;

    // first threshold above the count picks the chunk
    function automatic logic [CHUNK_WIDTH-1:0] ladder_chunk(
        input logic [COUNT_WIDTH-1:0] count
    );
        logic [CHUNK_WIDTH-1:0] res;
        res = TOP_CHUNK;
        for (int i = STEP_COUNT - 1; i >= 0; i--) begin
            if (count < COUNT_WIDTH'(STEP_LIMIT[i])) begin
                res = STEP_CHUNK[i];
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/ags_ladder.sv -----
// ----------------------------------------------------------------------------
// Array growth sizer: chunk selection stage
// Picks the ladder chunk, keeps the larger of it and the current chunk and
// loads the head of the remainder chain.
// ----------------------------------------------------------------------------
module ags_ladder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  ags_pkg::t_req i_req,
    output ags_pkg::t_lane o_lane
);
    import ags_pkg::*;

    t_lane r_lane;
    logic [CHUNK_WIDTH-1:0] n_chunk;
    logic [CHUNK_WIDTH-1:0] ladder;

    // ladder lookup and max with the chunk in use
    always_comb begin
        ladder  = ladder_chunk(i_req.element_count);
        n_chunk = (ladder < i_req.current_chunk) ? i_req.current_chunk : ladder;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_load;
        end
        r_lane.count <= i_req.element_count;
        r_lane.chunk <= n_chunk;
        r_lane.rem   <= '0;
    end

    assign o_lane = r_lane;

endmodule

// ----- sv/ags_cell.sv -----
// ----------------------------------------------------------------------------
// Array growth sizer: remainder cell
// One restoring division step: brings in the next count bit and subtracts
// the chunk when it fits.
// ----------------------------------------------------------------------------
module ags_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ags_pkg::t_lane i_lane,
    output ags_pkg::t_lane o_lane
);
    import ags_pkg::*;

    t_lane r_lane;
    logic [CHUNK_WIDTH:0]   shifted;
    logic [CHUNK_WIDTH:0]   diff;
    logic [CHUNK_WIDTH-1:0] n_rem;

    // shift in count MSB, trial subtract
    always_comb begin
        shifted = {i_lane.rem, i_lane.count[COUNT_WIDTH-1]};
        diff    = shifted - {1'b0, i_lane.chunk};
        n_rem   = (shifted >= {1'b0, i_lane.chunk}) ? diff[CHUNK_WIDTH-1:0]
                                                   : shifted[CHUNK_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else begin
            r_lane.valid <= i_lane.valid;
        end
        // rotate so the count is whole again after the last cell
        r_lane.count <= {i_lane.count[COUNT_WIDTH-2:0], i_lane.count[COUNT_WIDTH-1]};
        r_lane.chunk <= i_lane.chunk;
        r_lane.rem   <= n_rem;
    end

    assign o_lane = r_lane;

endmodule

// ----- sv/array_growth_sizer.sv -----
// ----------------------------------------------------------------------------
// Array growth sizer
// Chooses a growth chunk and rounds the element count up to a multiple of it.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+-------------------------------------
//  request   | start, i_req           | taken when start high and busy low
//  response  | o_valid, o_rsp         | one-cycle strobe, cannot be held off
//
// A request is accepted every cycle while busy is low. Each request passes
// through the chunk selection register, one remainder cell per count bit
// and the register that holds the final size sum.
// busy is high only while reset is applied and in the cycle after it.
// Synchronous active-low reset clears the valid bits of every stage.
// ----------------------------------------------------------------------------
module array_growth_sizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ags_pkg::t_req i_req,
    output logic          o_valid,
    output ags_pkg::t_rsp o_rsp
);
    import ags_pkg::*;

    t_lane lanes [COUNT_WIDTH+1];
    logic  r_busy;
    logic  r_valid;
    t_rsp  r_rsp;
    logic [SUM_WIDTH-1:0] n_sum;

    // busy out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // chunk selection
    ags_ladder u_ladder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (start & ~r_busy),
        .i_req   (i_req),
        .o_lane  (lanes[0])
    );

    // remainder chain, one cell per count bit
    for (genvar g = 0; g < COUNT_WIDTH; g++) begin : g_cell
        ags_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lane  (lanes[g]),
            .o_lane  (lanes[g+1])
        );
    end

    // round up: count - rem + chunk when rem is non-zero
    always_comb begin
        n_sum = SUM_WIDTH'(lanes[COUNT_WIDTH].count)
              - SUM_WIDTH'(lanes[COUNT_WIDTH].rem);
        if (lanes[COUNT_WIDTH].rem != '0) begin
            n_sum = n_sum + SUM_WIDTH'(lanes[COUNT_WIDTH].chunk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= lanes[COUNT_WIDTH].valid;
        end
        r_rsp.chunk_size <= lanes[COUNT_WIDTH].chunk;
        r_rsp.array_size <= n_sum[SIZE_WIDTH-1:0];
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ----- dv/array_growth_sizer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Array growth sizer testbench
// Drives sizing requests through the start/busy handshake and checks every
// response strobe against a local model of the chunk ladder and round-up.
// Directed corner requests come first, then random traffic with idle bursts,
// a pause that lets the pipeline drain, and a closing back-to-back stretch.
// ----------------------------------------------------------------------------
module array_growth_sizer_test;
    import ags_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int PIPE_LATENCY  = COUNT_WIDTH + 2;
    localparam int LADDER_STEPS  = 20;
    localparam int MAX_CHUNK     = 65535;
    localparam logic [63:0] WIDEST_CHUNK = 64'd60750;

    // count limits of the growth ladder and the chunk picked below each
    localparam logic [63:0] GROWTH_LIMIT [LADDER_STEPS] = '{
        64'd2,     64'd4,     64'd8,     64'd16,    64'd64,    64'd192,
        64'd288,   64'd432,   64'd648,   64'd972,   64'd1458,  64'd2916,
        64'd4374,  64'd8748,  64'd13122, 64'd26244, 64'd39366, 64'd65610,
        64'd109350, 64'd182250
    };
    localparam logic [63:0] GROWTH_CHUNK [LADDER_STEPS] = '{
        64'd1,     64'd2,     64'd4,     64'd8,     64'd16,    64'd32,
        64'd48,    64'd72,    64'd108,   64'd162,   64'd243,   64'd486,
        64'd729,   64'd1458,  64'd2187,  64'd4374,  64'd6561,  64'd13122,
        64'd21870, 64'd36450
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_valid;
    t_rsp o_rsp;

    t_rsp pending_sizes [$];
    int   mismatch_count = 0;
    bit   idle_enabled   = 1'b1;

    array_growth_sizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #(CLK_PERIOD * 400000);
        $display("array_growth_sizer: mismatch");
        $finish;
    end

    // ladder chunk, widened by the current chunk, then round the count up
    function automatic t_rsp size_for_growth(input t_req req);
        logic [63:0] count;
        logic [63:0] chunk;
        logic [63:0] groups;
        t_rsp        rsp;
        count = 64'(req.element_count);
        chunk = WIDEST_CHUNK;
        for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
            if (count < GROWTH_LIMIT[i]) begin
                chunk = GROWTH_CHUNK[i];
            end
        end
        if (chunk < 64'(req.current_chunk)) begin
            chunk = 64'(req.current_chunk);
        end
        groups = count / chunk;
        if (count % chunk != 0) begin
            groups = groups + 1;
        end
        rsp.chunk_size = chunk[CHUNK_WIDTH-1:0];
        rsp.array_size = SIZE_WIDTH'(groups * chunk);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40) begin
            $display("%0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // hand one request over; start stays high on return
    task automatic send_request(input t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        pending_sizes.push_back(size_for_growth(req));
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    function automatic t_req make_request(input logic [31:0] count, input int chunk);
        t_req req;
        req               = '0;
        req.element_count = COUNT_WIDTH'(count);
        req.current_chunk = CHUNK_WIDTH'(chunk);
        return req;
    endfunction

    // counts weighted towards ladder steps, chunks towards the interesting ends
    function automatic t_req random_request();
        logic [31:0] count;
        int          chunk;
        int          step;
        case ($urandom_range(0, 9))
            0, 1, 2: count = $urandom_range(0, 200000);
            3, 4, 5: begin
                step  = $urandom_range(0, LADDER_STEPS - 1);
                count = 32'(GROWTH_LIMIT[step]) + 32'($urandom_range(0, 4)) - 32'd2;
            end
            6:       count = $urandom_range(0, 20);
            7:       count = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            default: count = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: chunk = 0;
            3, 4:    chunk = $urandom_range(1, 300);
            5:       chunk = MAX_CHUNK - $urandom_range(0, 3);
            6:       chunk = 1 << $urandom_range(0, 15);
            default: chunk = $urandom_range(0, MAX_CHUNK);
        endcase
        return make_request(count, chunk);
    endfunction

    // response checker: each strobe against the oldest outstanding request
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (pending_sizes.size() == 0) begin
                report_mismatch($sformatf("unexpected response chunk %0d size %0d",
                                          o_rsp.chunk_size, o_rsp.array_size));
            end else begin
                want = pending_sizes.pop_front();
                if (o_rsp.chunk_size !== want.chunk_size) begin
                    report_mismatch($sformatf("chunk_size got %0d want %0d",
                                              o_rsp.chunk_size, want.chunk_size));
                end
                if (o_rsp.array_size !== want.array_size) begin
                    report_mismatch($sformatf("array_size got %0d want %0d",
                                              o_rsp.array_size, want.array_size));
                end
            end
        end
    end

    // zero count, full-scale count and chunk, ladder edges, zero current chunk
    task automatic test_ladder_corners();
        send_request(make_request(32'd0, 0));
        send_request(make_request(32'd0, MAX_CHUNK));
        send_request(make_request(32'd1, 0));
        send_request(make_request(32'd1, MAX_CHUNK));
        send_request(make_request(32'd2, 0));
        send_request(make_request(32'd15, 0));
        send_request(make_request(32'd16, 0));
        send_request(make_request(32'd63, 0));
        send_request(make_request(32'd64, 0));
        idle_burst();
        send_request(make_request(32'd2915, 0));
        send_request(make_request(32'd2916, 0));
        send_request(make_request(32'd4374, 1000));
        send_request(make_request(32'd109350, 3));
        send_request(make_request(32'd182249, 0));
        send_request(make_request(32'd182250, 0));
        send_request(make_request(32'd182251, 60751));
        send_request(make_request(32'hFFFF_FFFF, 0));
        send_request(make_request(32'hFFFF_FFFF, MAX_CHUNK));
        send_request(make_request(32'hFFFF_FFFE, 1));
        send_request(make_request(32'h8000_0000, 32768));
        send_request(make_request(32'h5555_5555, 16'hAAAA));
        send_request(make_request(32'hAAAA_AAAA, 16'h5555));
    endtask

    // random requests; idle bursts switch on and off in stretches of 64
    task automatic test_mixed_traffic(input int n_requests);
        bit gaps_now;
        gaps_now = 1'b1;
        for (int i = 0; i < n_requests; i++) begin
            if (i % 64 == 0) begin
                gaps_now = idle_enabled && ($urandom_range(0, 2) != 0);
            end
            send_request(random_request());
            if (gaps_now && $urandom_range(0, 3) == 0) begin
                idle_burst();
            end
        end
    endtask

    // hold requests off until every response has come back
    task automatic test_pause_until_drained();
        start <= 1'b0;
        while (pending_sizes.size() != 0) @(posedge i_clk);
    endtask

    // closing stretch with a request every cycle
    task automatic test_back_to_back(input int n_requests);
        idle_enabled = 1'b0;
        test_mixed_traffic(n_requests);
    endtask

    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ladder_corners();
        test_mixed_traffic(900);
        test_pause_until_drained();
        test_mixed_traffic(800);
        test_back_to_back(300);
        start <= 1'b0;

        // let the pipeline empty, then keep watching for stray strobes
        waited = 0;
        while (pending_sizes.size() != 0 && waited < 10 * PIPE_LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_sizes.size() != 0) begin
            report_mismatch($sformatf("%0d responses never arrived", pending_sizes.size()));
        end
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("array_growth_sizer: match");
        end else begin
            $display("array_growth_sizer: mismatch");
        end
        $finish;
    end

endmodule
